/* design/rbfk_pkg.sv */
`default_nettype none
package rbfk_pkg;

  localparam int ELEM_W = 16;
  localparam int SQ_W = 32;
  localparam int SUM_W = 48;
  localparam int GAMMA_W = 20;
  localparam int KERNEL_W = 16;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [GAMMA_W-1:0] GAMMA_RESET = 20'd3277;
  localparam logic [16:0] LOG2E_Q16 = 17'd94548;
  localparam logic [19:0] T_LIMIT = 20'd786432;

  typedef enum logic [3:0] {
    B_IDLE,
    B_PROD_LO,
    B_PROD_HI,
    B_ROUND,
    B_LOG2,
    B_INTERP,
    B_SCALE,
    B_SHIFT,
    B_DONE
  } back_state_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Table of round(65536 * 2^(-i/16)) for i from 0 to 16.
  function automatic logic [16:0] pow2_tab(input logic [4:0] idx);
    logic [16:0] r;
    unique case (idx)
      5'd0:    r = 17'd65536;
      5'd1:    r = 17'd62757;
      5'd2:    r = 17'd60097;
      5'd3:    r = 17'd57549;
      5'd4:    r = 17'd55109;
      5'd5:    r = 17'd52773;
      5'd6:    r = 17'd50535;
      5'd7:    r = 17'd48393;
      5'd8:    r = 17'd46341;
      5'd9:    r = 17'd44376;
      5'd10:   r = 17'd42495;
      5'd11:   r = 17'd40693;
      5'd12:   r = 17'd38968;
      5'd13:   r = 17'd37316;
      5'd14:   r = 17'd35734;
      5'd15:   r = 17'd34219;
      5'd16:   r = 17'd32768;
      default: r = 17'd32768;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

/* design/rbfk_front.sv */
`default_nettype none
module rbfk_front (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [4*rbfk_pkg::ELEM_W-1:0] in_data,
  input  wire logic                        in_last,
  input  wire rbfk_pkg::q_stat_t           q_stat,
  output logic                             q_push,
  output logic [rbfk_pkg::SUM_W-1:0]       q_push_data
);

  logic signed [rbfk_pkg::ELEM_W:0] d0;
  logic signed [rbfk_pkg::ELEM_W:0] d1;
  logic [rbfk_pkg::ELEM_W:0]        m0;
  logic [rbfk_pkg::ELEM_W:0]        m1;
  logic                             s1_valid;
  logic                             s1_last;
  logic [rbfk_pkg::SQ_W-1:0]        sq0;
  logic [rbfk_pkg::SQ_W-1:0]        sq1;
  logic                             s1_adv;
  logic [rbfk_pkg::SUM_W-1:0]       sum;
  logic [rbfk_pkg::SUM_W+1:0]       total;
  logic [rbfk_pkg::SUM_W-1:0]       clamped;

  assign d0 = {in_data[15], in_data[15:0]} - {in_data[47], in_data[47:32]};
  assign d1 = {in_data[31], in_data[31:16]} - {in_data[63], in_data[63:48]};
  assign m0 = d0[16] ? 17'(-d0) : 17'(d0);
  assign m1 = d1[16] ? 17'(-d1) : 17'(d1);

  assign s1_adv = s1_valid && (!s1_last || !q_stat.full);
  assign in_ready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      sq0 <= m0[15:0] * m0[15:0];
      sq1 <= m1[15:0] * m1[15:0];
      s1_last <= in_last;
    end
  end

  // Both squares are non-negative, so one clamp after the two adds matches
  // saturating after each of them.
  assign total = 50'(sum) + 50'(sq0) + 50'(sq1);
  assign clamped = (|total[rbfk_pkg::SUM_W+1:rbfk_pkg::SUM_W]) ? '1 : total[rbfk_pkg::SUM_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      sum <= '0;
    end else if (s1_adv) begin
      sum <= s1_last ? '0 : clamped;
    end
  end

  assign q_push = s1_adv && s1_last;
  assign q_push_data = clamped;

endmodule
`default_nettype wire

/* design/rbfk_queue.sv */
`default_nettype none
module rbfk_queue #(
  parameter int DEPTH = rbfk_pkg::QUEUE_DEPTH
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        push,
  input  wire logic [rbfk_pkg::SUM_W-1:0]  push_data,
  input  wire logic                        pop,
  output logic [rbfk_pkg::SUM_W-1:0]       pop_data,
  output rbfk_pkg::q_stat_t                stat
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [rbfk_pkg::SUM_W-1:0] mem [DEPTH];
  logic [PTR_W-1:0]           wr_ptr;
  logic [PTR_W-1:0]           rd_ptr;
  logic [CNT_W-1:0]           count;

  assign stat.full = (count == CNT_W'(DEPTH));
  assign stat.empty = (count == '0);
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef SYNTH
  a_no_push_full: assert property (@(posedge clk) disable iff (rst) !(push && stat.full))
    else $error("queue written while full");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) !(pop && stat.empty))
    else $error("queue read while empty");
  a_count_range: assert property (@(posedge clk) disable iff (rst) count <= CNT_W'(DEPTH))
    else $error("queue count out of range");
`endif

endmodule
`default_nettype wire

/* design/rbfk_back.sv */
`default_nettype none
module rbfk_back (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_valid,
  input  wire logic [rbfk_pkg::GAMMA_W-1:0]  cfg_data,
  input  wire rbfk_pkg::q_stat_t             q_stat,
  input  wire logic [rbfk_pkg::SUM_W-1:0]    q_data,
  output logic                               q_pop,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [rbfk_pkg::KERNEL_W-1:0]      out_data
);

  rbfk_pkg::back_state_t state;
  rbfk_pkg::back_state_t state_next;

  logic [rbfk_pkg::GAMMA_W-1:0] gamma;
  logic [43:0]                  sum_r;
  logic [41:0]                  prod_lo;
  logic [41:0]                  prod_hi;
  logic [64:0]                  rsum;
  logic [40:0]                  t_r;
  logic [36:0]                  upr;
  logic [20:0]                  u_r;
  logic                         big_r;
  logic [4:0]                   k_r;
  logic [16:0]                  tv_r;
  logic [16:0]                  tab_a;
  logic [16:0]                  tab_b;
  logic [11:0]                  delta;
  logic [23:0]                  pi_r;
  logic [24:0]                  pi_rnd;
  logic [16:0]                  v_r;
  logic [17:0]                  rnd;
  logic [17:0]                  shifted;
  logic [rbfk_pkg::KERNEL_W-1:0] result;
  logic                         special;
  logic                         out_load;
  logic                         out_free;

  assign out_free = !out_valid || out_ready;
  assign special = (gamma == '0) || (|q_data[rbfk_pkg::SUM_W-1:44]);

  always_ff @(posedge clk) begin
    if (rst) begin
      gamma <= rbfk_pkg::GAMMA_RESET;
    end else if (cfg_valid) begin
      gamma <= cfg_data;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      rbfk_pkg::B_IDLE: begin
        if (!q_stat.empty) begin
          state_next = special ? rbfk_pkg::B_DONE : rbfk_pkg::B_PROD_LO;
        end
      end
      rbfk_pkg::B_PROD_LO: state_next = rbfk_pkg::B_PROD_HI;
      rbfk_pkg::B_PROD_HI: state_next = rbfk_pkg::B_ROUND;
      rbfk_pkg::B_ROUND:   state_next = rbfk_pkg::B_LOG2;
      rbfk_pkg::B_LOG2:    state_next = rbfk_pkg::B_INTERP;
      rbfk_pkg::B_INTERP:  state_next = rbfk_pkg::B_SCALE;
      rbfk_pkg::B_SCALE:   state_next = rbfk_pkg::B_SHIFT;
      rbfk_pkg::B_SHIFT:   state_next = rbfk_pkg::B_DONE;
      rbfk_pkg::B_DONE: begin
        if (out_free) begin
          state_next = rbfk_pkg::B_IDLE;
        end
      end
      default: state_next = rbfk_pkg::B_IDLE;
    endcase
  end

  always_comb begin
    q_pop = 1'b0;
    out_load = 1'b0;
    unique case (state)
      rbfk_pkg::B_IDLE: q_pop = !q_stat.empty;
      rbfk_pkg::B_DONE: out_load = out_free;
      default: begin
        q_pop = 1'b0;
        out_load = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rbfk_pkg::B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign rsum = {1'b0, prod_hi, 22'd0} + 65'(prod_lo) + (65'd1 << 23);
  assign upr = 37'(t_r[19:0]) * 37'(rbfk_pkg::LOG2E_Q16) + 37'd32768;
  assign tab_a = rbfk_pkg::pow2_tab({1'b0, u_r[15:12]});
  assign tab_b = rbfk_pkg::pow2_tab(5'({1'b0, u_r[15:12]}) + 5'd1);
  assign delta = 12'(tab_a - tab_b);
  assign pi_rnd = 25'(pi_r) + 25'd2048;
  assign rnd = (k_r == '0) ? '0 : (18'd1 << (k_r - 5'd1));
  assign shifted = ({1'b0, v_r} + rnd) >> k_r;

  always_comb begin
    if (big_r || k_r > 5'd16) begin
      result = '0;
    end else if (|shifted[17:16]) begin
      result = '1;
    end else begin
      result = shifted[15:0];
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      rbfk_pkg::B_IDLE: begin
        sum_r <= q_data[43:0];
        big_r <= (gamma != '0);
        k_r <= '0;
        v_r <= (gamma == '0) ? 17'd65536 : 17'd0;
      end
      rbfk_pkg::B_PROD_LO: prod_lo <= 42'(gamma) * 42'(sum_r[21:0]);
      rbfk_pkg::B_PROD_HI: prod_hi <= 42'(gamma) * 42'(sum_r[43:22]);
      rbfk_pkg::B_ROUND:   t_r <= rsum[64:24];
      rbfk_pkg::B_LOG2: begin
        big_r <= (|t_r[40:20]) || (t_r[19:0] >= rbfk_pkg::T_LIMIT);
        u_r <= upr[36:16];
      end
      rbfk_pkg::B_INTERP: begin
        k_r <= u_r[20:16];
        tv_r <= tab_a;
        pi_r <= 24'(delta) * 24'(u_r[11:0]);
      end
      rbfk_pkg::B_SCALE:   v_r <= tv_r - 17'(pi_rnd[24:12]);
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data <= result;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

`ifndef SYNTH
  a_load_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == rbfk_pkg::B_DONE)
    else $error("result presented outside the done step");
  a_pop_only_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> state != rbfk_pkg::B_IDLE)
    else $error("sequencer did not start after taking a sum");
`endif

endmodule
`default_nettype wire

/* design/rbf_kernel_distance_exp.sv */
`default_nettype none
// Gaussian RBF kernel of two streamed feature vectors. Each input word carries two
// element pairs; its squared differences are registered and then added into a saturating
// 48-bit sum. The word marked last closes the vector, and its sum goes into a two-entry
// queue to the exponential sequencer, which works through one sum in steps (taking it
// from the queue, two partial products of gamma times the sum, a rounding step, the
// log2(e) scaling, table interpolation, the subtraction and the final power-of-two shift
// into the output register). When gamma is zero or the sum is 2^44 or more the result is
// fixed and the sequencer goes straight from taking the sum to loading the output. Input
// words keep streaming while the sequencer works; only a word marked last is held, and
// only while two finished vectors are already in the queue; words behind it then wait.
// gamma is written on the configuration channel, which is always ready, and should only
// change while no vector is in flight.
module rbf_kernel_distance_exp #(
  parameter int QUEUE_DEPTH = rbfk_pkg::QUEUE_DEPTH
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         s_tvalid,
  output logic                              s_tready,
  // x_first, x_second, y_first, y_second
  input  wire logic [4*rbfk_pkg::ELEM_W-1:0] s_tdata,
  input  wire logic                         s_tlast,
  output logic                              m_tvalid,
  input  wire logic                         m_tready,
  // kernel_value
  output logic [rbfk_pkg::KERNEL_W-1:0]     m_tdata,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [rbfk_pkg::GAMMA_W-1:0] cfg_data
);

  rbfk_pkg::q_stat_t          q_stat;
  logic                       q_push;
  logic [rbfk_pkg::SUM_W-1:0] q_push_data;
  logic                       q_pop;
  logic [rbfk_pkg::SUM_W-1:0] q_pop_data;

  assign cfg_ready = 1'b1;

  rbfk_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .in_data     (s_tdata),
    .in_last     (s_tlast),
    .q_stat      (q_stat),
    .q_push      (q_push),
    .q_push_data (q_push_data)
  );

  rbfk_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_push_data),
    .pop       (q_pop),
    .pop_data  (q_pop_data),
    .stat      (q_stat)
  );

  rbfk_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .q_stat    (q_stat),
    .q_data    (q_pop_data),
    .q_pop     (q_pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata)
  );

endmodule
`default_nettype wire
